@@ rtl/core/uvs_pkg.sv @@
// shared types, constants and tables of the uv sphere tessellator
`timescale 1ns / 1ps
package uvs_pkg;

  localparam int unsigned MAX_BANDS_DEF  = 256;
  localparam int unsigned ANGLE_BITS_DEF = 16;

  localparam int unsigned STEP_W     = 9;
  localparam int unsigned BAND_W     = 9;
  localparam int unsigned RAD_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned POS_W      = 17;
  localparam int unsigned NORM_W     = 16;
  localparam int unsigned TEX_W      = 17;
  localparam int unsigned IDX_W      = 17;

  // angles in turn units, sine and cosine at scale 2^30
  localparam int unsigned TURN_W       = 32;
  localparam int unsigned CS_W         = 32;
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned CORDIC_LAT   = CORDIC_STEPS + 2;
  localparam int unsigned MUL_LAT      = 2;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAT_BANDS = 2'd0,
    CFG_LON_BANDS = 2'd1,
    CFG_RADIUS    = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ACT_VERTEX = 1'b0,
    ACT_QUAD   = 1'b1
  } action_e;

  typedef struct packed {
    logic              valid;
    action_e           act;
    logic [STEP_W-1:0] lat;
    logic [STEP_W-1:0] lon;
  } meta_t;

  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] r;
    case (i)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      24: r = 32'd41;
      25: r = 32'd20;
      26: r = 32'd10;
      27: r = 32'd5;
      28: r = 32'd3;
      29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/uvs_ifs.sv @@
// handshake interfaces of the uv sphere tessellator
`timescale 1ns / 1ps
interface uvs_req_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [uvs_pkg::STEP_W-1:0]    lat_step;
  logic [uvs_pkg::STEP_W-1:0]    lon_step;
  modport source (output valid, action, lat_step, lon_step, input ready);
  modport sink (input valid, action, lat_step, lon_step, output ready);
  modport monitor (input valid, ready, action, lat_step, lon_step);
endinterface

interface uvs_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [uvs_pkg::POS_W-1:0]   pos_x;
  logic signed [uvs_pkg::POS_W-1:0]   pos_y;
  logic signed [uvs_pkg::POS_W-1:0]   pos_z;
  logic signed [uvs_pkg::NORM_W-1:0]  norm_x;
  logic signed [uvs_pkg::NORM_W-1:0]  norm_y;
  logic signed [uvs_pkg::NORM_W-1:0]  norm_z;
  logic [uvs_pkg::TEX_W-1:0]          tex_u;
  logic [uvs_pkg::TEX_W-1:0]          tex_v;
  logic [uvs_pkg::IDX_W-1:0]          tri_a;
  logic [uvs_pkg::IDX_W-1:0]          tri_b;
  logic [uvs_pkg::IDX_W-1:0]          tri_c;
  logic                               last;
  modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
                  tri_a, tri_b, tri_c, last, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
                tri_a, tri_b, tri_c, last, output ready);
  modport monitor (input valid, ready, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u,
                   tex_v, tri_a, tri_b, tri_c, last);
endinterface

interface uvs_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [uvs_pkg::CFG_IDX_W-1:0]     index;
  logic [uvs_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
  modport monitor (input valid, ready, index, data);
endinterface

@@ rtl/core/uvs_pipe.sv @@
// stalling delay line for side-band words
`timescale 1ns / 1ps
module uvs_pipe #(
  parameter int unsigned W     = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);
  logic [W-1:0] sr_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) sr_q[i] <= '0;
    end else if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) sr_q[i] <= sr_q[i-1];
    end
  end

  assign q_o = sr_q[DEPTH-1];
endmodule

@@ rtl/core/uvs_div.sv @@
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module uvs_div #(
  parameter int unsigned DW = 11,
  parameter int unsigned QW = 17
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [QW+DW-1:0] num_i,
  input  logic [DW-1:0]    den_i,
  output logic [QW-1:0]    quo_o
);
  // quotient is known to fit QW bits, so the top part is already below the divisor
  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] sh_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] sh_in;
    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          ge;
    if (k == 0) begin : g_first
      assign rem_in = num_i[QW +: DW];
      assign sh_in  = num_i[QW-1:0];
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign sh_in  = sh_q[k-1];
    end
    assign t    = {rem_in, sh_in[QW-1]};
    assign ge   = t >= {1'b0, den_i};
    assign diff = t - {1'b0, den_i};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[DW-1:0] : t[DW-1:0];
        sh_q[k]  <= {sh_in[QW-2:0], ge};
      end
    end
  end

  assign quo_o = sh_q[QW-1];
endmodule

@@ rtl/core/uvs_cordic.sv @@
// pipelined cordic rotator, one micro-rotation per stage, quadrant folded
`timescale 1ns / 1ps
module uvs_cordic (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [uvs_pkg::TURN_W-1:0]          ang_i,
  output logic signed [uvs_pkg::CS_W-1:0]     cos_o,
  output logic signed [uvs_pkg::CS_W-1:0]     sin_o
);
  import uvs_pkg::*;

  localparam int unsigned XW = 34;
  localparam int unsigned ZW = 33;

  logic signed [XW-1:0] x_q [CORDIC_STEPS+1];
  logic signed [XW-1:0] y_q [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z_q [CORDIC_STEPS+1];
  logic [1:0]           quad_q [CORDIC_STEPS+1];

  logic [TURN_W-1:0] sum;
  logic [1:0]        quad;
  logic [TURN_W-1:0] zr;

  // nearest quadrant, residual within one eighth of a turn
  assign sum  = ang_i + 32'h2000_0000;
  assign quad = sum[TURN_W-1 -: 2];
  assign zr   = ang_i - {quad, 30'd0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= CORDIC_GAIN;
      y_q[0]    <= '0;
      z_q[0]    <= $signed({zr[TURN_W-1], zr});
      quad_q[0] <= quad;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] at;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign at = $signed({1'b0, atan_turn(i)});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quad_q[i+1] <= quad_q[i];
        if (!z_q[i][ZW-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + at;
        end
      end
    end
  end

  logic signed [XW-1:0] xf;
  logic signed [XW-1:0] yf;
  logic signed [XW-1:0] nxf;
  logic signed [XW-1:0] nyf;
  assign xf  = x_q[CORDIC_STEPS];
  assign yf  = y_q[CORDIC_STEPS];
  assign nxf = -xf;
  assign nyf = -yf;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (quad_q[CORDIC_STEPS])
        2'd0: begin
          cos_o <= xf[CS_W-1:0];
          sin_o <= yf[CS_W-1:0];
        end
        2'd1: begin
          cos_o <= nyf[CS_W-1:0];
          sin_o <= xf[CS_W-1:0];
        end
        2'd2: begin
          cos_o <= nxf[CS_W-1:0];
          sin_o <= nyf[CS_W-1:0];
        end
        default: begin
          cos_o <= yf[CS_W-1:0];
          sin_o <= nxf[CS_W-1:0];
        end
      endcase
    end
  end
endmodule

@@ rtl/core/uv_sphere_vertex_index_generator.sv @@
// top level of the uv sphere tessellator
`timescale 1ns / 1ps
// UV sphere tessellator. A vertex request (action 0) returns one word with the position
// (signed Q8.8), the unit normal (signed Q1.15) and the texture coordinates (unsigned
// Q1.16) of the vertex at latitude step lat and longitude step lon; a quad request
// (action 1) returns two words, the two triangles of vertex indices of that quad, with
// last high on the second. Steps beyond the band counts saturate. Rate, set by the
// single output register that hands out one word per cycle when it is taken: one
// vertex request per cycle, while a quad request holds the input until both of its
// words are taken. From acceptance to the first word the data pass the input
// register, bit-serial-in-space dividers for the angle and texture fractions, a
// 30-step cordic rotator plus quadrant stages, a multiply stage, a rounding stage and
// the output register. The whole pipe advances together and holds when the output
// word is not taken; the band and radius registers are written through the
// configuration channel, which is always ready, and must only change while idle.
module uv_sphere_vertex_index_generator #(
  parameter int unsigned MAX_BANDS  = uvs_pkg::MAX_BANDS_DEF,
  parameter int unsigned ANGLE_BITS = uvs_pkg::ANGLE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  uvs_cfg_if.sink   cfg_i,
  uvs_req_if.sink   req_i,
  uvs_rsp_if.source rsp_o
);
  import uvs_pkg::*;

  // band count width, wide enough for the largest band count
  localparam int unsigned BW   = ($clog2(MAX_BANDS + 1) > BAND_W) ?
                                 $clog2(MAX_BANDS + 1) : BAND_W;
  localparam int unsigned QW   = (ANGLE_BITS + 1 > TEX_W) ? ANGLE_BITS + 1 : TEX_W;
  localparam int unsigned DW   = BW + 2;
  localparam int unsigned NUMW = QW + DW;
  localparam int unsigned FW   = STEP_W + BW + 2;
  localparam logic [BW-1:0] BAND_MAX = BW'(MAX_BANDS);
  localparam logic [BW-1:0] BAND_MIN = BW'(3);

  function automatic logic [BW-1:0] clamp_bands(input logic [BAND_W-1:0] v);
    logic [BW-1:0] r;
    r = BW'(v);
    if (r < BAND_MIN) r = BAND_MIN;
    else if (r > BAND_MAX) r = BAND_MAX;
    return r;
  endfunction

  function automatic logic signed [NORM_W-1:0] sat16(input logic signed [19:0] v);
    logic signed [NORM_W-1:0] r;
    if (v > 20'sd32767) r = 16'sh7FFF;
    else if (v < -20'sd32768) r = 16'sh8000;
    else r = v[NORM_W-1:0];
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] to_pos(input logic [RAD_W-1:0] rad,
                                                     input logic signed [NORM_W-1:0] n);
    logic signed [32:0] p;
    logic signed [32:0] t;
    p = $signed({1'b0, rad}) * n;
    t = p + 33'sd16384;
    return t[31:15];
  endfunction

  // ---------------------------------------------------------------- configuration
  // band counts are stored already clamped to the legal range
  logic [BW-1:0]    nlat_q;
  logic [BW-1:0]    nlon_q;
  logic [RAD_W-1:0] rad_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nlat_q <= BW'(16);
      nlon_q <= BW'(16);
      rad_q  <= RAD_W'(256);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_LAT_BANDS: nlat_q <= clamp_bands(cfg_i.data[BAND_W-1:0]);
        CFG_LON_BANDS: nlon_q <= clamp_bands(cfg_i.data[BAND_W-1:0]);
        CFG_RADIUS:    rad_q  <= cfg_i.data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- pipe control
  // output register: a quad word stays for two handshakes
  logic ov_q;
  logic osec_q;
  action_e oact_q;
  logic en;
  logic out_done;

  assign out_done    = ov_q && rsp_o.ready && ((oact_q != ACT_QUAD) || osec_q);
  assign en          = !ov_q || out_done;
  assign req_i.ready = en;

  // ---------------------------------------------------------------- input stage
  meta_t         a_meta_q;
  meta_t         a_meta_d;
  logic [BW-1:0] lat_lim;
  logic [BW-1:0] lon_lim;

  always_comb begin
    a_meta_d.valid = req_i.valid;
    a_meta_d.act   = action_e'(req_i.action);
    // quads stop one band short of the vertex range
    lat_lim = (a_meta_d.act == ACT_QUAD) ? nlat_q - BW'(1) : nlat_q;
    lon_lim = (a_meta_d.act == ACT_QUAD) ? nlon_q - BW'(1) : nlon_q;
    a_meta_d.lat = (BW'(req_i.lat_step) > lat_lim) ? lat_lim[STEP_W-1:0] : req_i.lat_step;
    a_meta_d.lon = (BW'(req_i.lon_step) > lon_lim) ? lon_lim[STEP_W-1:0] : req_i.lon_step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_meta_q <= '0;
    end else if (en) begin
      a_meta_q <= a_meta_d;
    end
  end

  // ---------------------------------------------------------------- dividers
  // rounded fractions: angle codes in turns, texture steps in Q1.16
  logic [NUMW-1:0] th_num;
  logic [NUMW-1:0] ph_num;
  logic [NUMW-1:0] tu_num;
  logic [NUMW-1:0] tv_num;
  logic [DW-1:0]   lat2_den;
  logic [DW-1:0]   lat4_den;
  logic [DW-1:0]   lon2_den;
  logic [QW-1:0]   th_quo;
  logic [QW-1:0]   ph_quo;
  logic [QW-1:0]   tu_quo;
  logic [QW-1:0]   tv_quo;

  assign lat2_den = {1'b0, nlat_q, 1'b0};
  assign lat4_den = {nlat_q, 2'b00};
  assign lon2_den = {1'b0, nlon_q, 1'b0};
  assign th_num   = (NUMW'(a_meta_q.lat) << (ANGLE_BITS + 1)) + NUMW'(lat2_den);
  assign ph_num   = (NUMW'(a_meta_q.lon) << (ANGLE_BITS + 1)) + NUMW'(nlon_q);
  assign tu_num   = (NUMW'(a_meta_q.lon) << TEX_W) + NUMW'(nlon_q);
  assign tv_num   = (NUMW'(a_meta_q.lat) << TEX_W) + NUMW'(nlat_q);

  uvs_div #(.DW(DW), .QW(QW)) u_div_th (
    .clk_i, .en_i(en), .num_i(th_num), .den_i(lat4_den), .quo_o(th_quo)
  );
  uvs_div #(.DW(DW), .QW(QW)) u_div_ph (
    .clk_i, .en_i(en), .num_i(ph_num), .den_i(lon2_den), .quo_o(ph_quo)
  );
  uvs_div #(.DW(DW), .QW(QW)) u_div_tu (
    .clk_i, .en_i(en), .num_i(tu_num), .den_i(lon2_den), .quo_o(tu_quo)
  );
  uvs_div #(.DW(DW), .QW(QW)) u_div_tv (
    .clk_i, .en_i(en), .num_i(tv_num), .den_i(lat2_den), .quo_o(tv_quo)
  );

  // ---------------------------------------------------------------- sine and cosine
  logic [TURN_W-1:0]      th_ang;
  logic [TURN_W-1:0]      ph_ang;
  logic signed [CS_W-1:0] ct;
  logic signed [CS_W-1:0] st;
  logic signed [CS_W-1:0] cp;
  logic signed [CS_W-1:0] sp;

  // angle code taken modulo a full turn, then placed at the top of the turn word
  assign th_ang = {th_quo[ANGLE_BITS-1:0], {(TURN_W - ANGLE_BITS){1'b0}}};
  assign ph_ang = {ph_quo[ANGLE_BITS-1:0], {(TURN_W - ANGLE_BITS){1'b0}}};

  uvs_cordic u_cordic_th (.clk_i, .en_i(en), .ang_i(th_ang), .cos_o(ct), .sin_o(st));
  uvs_cordic u_cordic_ph (.clk_i, .en_i(en), .ang_i(ph_ang), .cos_o(cp), .sin_o(sp));

  // ---------------------------------------------------------------- normals
  logic signed [63:0]     px_q;
  logic signed [63:0]     pz_q;
  logic signed [CS_W-1:0] ct1_q;
  logic signed [NORM_W-1:0] nx_q;
  logic signed [NORM_W-1:0] ny_q;
  logic signed [NORM_W-1:0] nz_q;
  logic signed [63:0]     rx;
  logic signed [63:0]     rz;
  logic signed [32:0]     ry;

  // q30 product rounding and q15 rounding folded into one offset and shift
  assign rx = px_q + 64'sd17592722915328;
  assign rz = pz_q + 64'sd17592722915328;
  assign ry = $signed({ct1_q[CS_W-1], ct1_q}) + 33'sd16384;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q  <= cp * st;
      pz_q  <= sp * st;
      ct1_q <= ct;
      nx_q  <= sat16({rx[63], rx[63:45]});
      nz_q  <= sat16({rz[63], rz[63:45]});
      ny_q  <= sat16({{2{ry[32]}}, ry[32:15]});
    end
  end

  // ---------------------------------------------------------------- side band
  meta_t                m_meta;
  logic [2*TEX_W-1:0]   tex_d;
  logic [2*TEX_W-1:0]   tex_m;

  assign tex_d = {tu_quo[TEX_W-1:0], tv_quo[TEX_W-1:0]};

  uvs_pipe #(.W($bits(meta_t)), .DEPTH(QW + CORDIC_LAT + MUL_LAT)) u_meta_pipe (
    .clk_i, .rst_ni, .en_i(en), .d_i(a_meta_q), .q_o(m_meta)
  );
  uvs_pipe #(.W(2 * TEX_W), .DEPTH(CORDIC_LAT + MUL_LAT)) u_tex_pipe (
    .clk_i, .rst_ni, .en_i(en), .d_i(tex_d), .q_o(tex_m)
  );

  // ---------------------------------------------------------------- output register
  logic signed [POS_W-1:0]  opx_q;
  logic signed [POS_W-1:0]  opy_q;
  logic signed [POS_W-1:0]  opz_q;
  logic signed [NORM_W-1:0] onx_q;
  logic signed [NORM_W-1:0] ony_q;
  logic signed [NORM_W-1:0] onz_q;
  logic [TEX_W-1:0]         otu_q;
  logic [TEX_W-1:0]         otv_q;
  logic [IDX_W-1:0]         of_q;
  logic [IDX_W-1:0]         os_q;
  logic [IDX_W-1:0]         of1_q;
  logic [IDX_W-1:0]         os1_q;
  logic [FW-1:0]            first_full;
  logic [IDX_W-1:0]         first_idx;
  logic [IDX_W-1:0]         second_idx;
  logic [TEX_W-1:0]         tex_one;

  // first corner of the quad and the one a row above it, indices kept to 17 bits
  assign first_full = FW'(m_meta.lat) * FW'({1'b0, nlon_q} + (BW + 1)'(1)) + FW'(m_meta.lon);
  assign first_idx  = first_full[IDX_W-1:0];
  assign second_idx = first_idx + IDX_W'(nlon_q) + IDX_W'(1);
  assign tex_one    = TEX_W'(65536);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      osec_q <= 1'b0;
      oact_q <= ACT_VERTEX;
    end else if (en) begin
      ov_q   <= m_meta.valid;
      osec_q <= 1'b0;
      oact_q <= m_meta.act;
    end else if (ov_q && rsp_o.ready) begin
      // first triangle of a quad taken, second one next
      osec_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      opx_q <= to_pos(rad_q, nx_q);
      opy_q <= to_pos(rad_q, ny_q);
      opz_q <= to_pos(rad_q, nz_q);
      onx_q <= nx_q;
      ony_q <= ny_q;
      onz_q <= nz_q;
      otu_q <= tex_one - tex_m[2*TEX_W-1 -: TEX_W];
      otv_q <= tex_one - tex_m[TEX_W-1:0];
      of_q  <= first_idx;
      os_q  <= second_idx;
      of1_q <= first_idx + IDX_W'(1);
      os1_q <= second_idx + IDX_W'(1);
    end
  end

  // ---------------------------------------------------------------- output word
  always_comb begin
    rsp_o.valid  = ov_q;
    rsp_o.pos_x  = '0;
    rsp_o.pos_y  = '0;
    rsp_o.pos_z  = '0;
    rsp_o.norm_x = '0;
    rsp_o.norm_y = '0;
    rsp_o.norm_z = '0;
    rsp_o.tex_u  = '0;
    rsp_o.tex_v  = '0;
    rsp_o.tri_a  = '0;
    rsp_o.tri_b  = '0;
    rsp_o.tri_c  = '0;
    rsp_o.last   = 1'b1;
    if (oact_q == ACT_QUAD) begin
      rsp_o.tri_c = of1_q;
      if (!osec_q) begin
        rsp_o.tri_a = of_q;
        rsp_o.tri_b = os_q;
        rsp_o.last  = 1'b0;
      end else begin
        rsp_o.tri_a = os_q;
        rsp_o.tri_b = os1_q;
      end
    end else begin
      rsp_o.pos_x  = opx_q;
      rsp_o.pos_y  = opy_q;
      rsp_o.pos_z  = opz_q;
      rsp_o.norm_x = onx_q;
      rsp_o.norm_y = ony_q;
      rsp_o.norm_z = onz_q;
      rsp_o.tex_u  = otu_q;
      rsp_o.tex_v  = otv_q;
    end
  end
endmodule
